/* src/pes_pkg.sv */
`default_nettype none
package pes_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DivBits  = 32 + FracBits;
  localparam int unsigned DivCntW  = $clog2(DivBits + 1);
  localparam int unsigned QueueDepth = 2;

  localparam logic signed [31:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinVal = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic        [31:0] mass;
    logic signed [31:0] age;
    logic        [31:0] time_step;
    logic               first_of_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_age;
    logic               alive;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } out_item_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic        [31:0] mass;
    logic        [31:0] time_step;
    logic signed [31:0] new_age;
    logic               alive;
    logic               first_of_frame;
  } work_t;

  typedef enum logic [3:0] {
    StIdle, StDivX, StDivY, StVelX, StVelY, StVelSum, StPosX, StPosY, StPosSum, StOut
  } back_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return MaxVal;
    if (v < -34'sd2147483648) return MinVal;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

/* src/pes_if.sv */
`default_nettype none
interface pes_in_if;
  logic valid;
  logic ready;
  pes_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pes_out_if;
  logic valid;
  logic ready;
  pes_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/pes_front.sv */
`default_nettype none
module pes_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pes_pkg::in_item_t in_data_i,
  output logic                  q_valid_o,
  input  wire logic             q_ready_i,
  output pes_pkg::work_t        q_data_o
);

  logic signed [33:0] age_diff;
  logic signed [31:0] nage;
  pes_pkg::work_t     work;
  pes_pkg::work_t     mem_q [pes_pkg::QueueDepth];
  logic [0:0]         wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q;
  logic               push, pop;

  // Age update and liveness classification.
  always_comb begin
    age_diff = {{2{in_data_i.age[31]}}, in_data_i.age} - {2'b00, in_data_i.time_step};
    nage = pes_pkg::sat32(age_diff);
    work.pos_x = in_data_i.pos_x;
    work.pos_y = in_data_i.pos_y;
    work.vel_x = in_data_i.vel_x;
    work.vel_y = in_data_i.vel_y;
    work.force_x = in_data_i.force_x;
    work.force_y = in_data_i.force_y;
    work.mass = in_data_i.mass;
    work.time_step = in_data_i.time_step;
    work.new_age = nage;
    work.alive = (nage > 32'sd0);
    work.first_of_frame = in_data_i.first_of_frame;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;
  assign q_valid_o = (count_q != 2'd0);
  assign q_data_o = mem_q[rd_ptr_q];

  // Two-entry queue toward the back.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= work;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

/* src/pes_div.sv */
`default_nettype none
module pes_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic signed [31:0] force_i,
  input  wire logic [31:0] mass_i,
  output logic             done_o,
  output logic signed [31:0] quot_o
);

  localparam int unsigned NB = pes_pkg::DivBits;

  logic [NB-1:0]  num_q;
  logic [NB-1:0]  quo_q;
  logic [32:0]    rem_q;
  logic [31:0]    den_q;
  logic           neg_q, busy_q;
  logic           zero_q;
  logic [pes_pkg::DivCntW-1:0] cnt_q;
  logic [32:0]    rem_sh;
  logic           fit;
  logic [31:0]    mag;
  logic [NB:0]    qsat;

  assign mag = force_i[31] ? (32'd0 - force_i) : force_i;
  assign rem_sh = {rem_q[31:0], num_q[NB-1]};
  assign fit = (rem_sh >= {1'b0, den_q});

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= pes_pkg::DivCntW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == pes_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag, {pes_pkg::FracBits{1'b0}}};
      den_q <= mass_i;
      neg_q <= force_i[31];
      zero_q <= (mag == 32'd0);
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= fit ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[NB-2:0], fit};
    end
  end

  // Sign and saturation of the quotient; a zero force always gives zero,
  // even over a zero mass.
  always_comb begin
    qsat = {1'b0, quo_q};
    if (zero_q) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = (qsat >= (NB+1)'(33'h0_8000_0000)) ? pes_pkg::MinVal
             : -$signed(quo_q[31:0]);
    end else begin
      quot_o = (qsat >= (NB+1)'(33'h0_8000_0000)) ? pes_pkg::MaxVal
             : $signed(quo_q[31:0]);
    end
  end

endmodule
`default_nettype wire

/* src/pes_back.sv */
`default_nettype none
module pes_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  output logic                q_ready_o,
  input  wire pes_pkg::work_t q_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pes_pkg::out_item_t  out_data_o
);

  pes_pkg::back_state_e state_q, state_d;
  pes_pkg::work_t w_q;
  logic signed [31:0] ax_q, ay_q, vx_q, vy_q, px_q, py_q;
  logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [33:0] prod_q;
  logic signed [33:0] prod_y_q;
  logic               div_start, div_done;
  logic signed [31:0] div_force, div_quot;
  logic [31:0]        div_mass;
  logic signed [31:0] mul_a;
  logic [31:0]        mul_mag;
  logic [63:0]        mul_full;
  logic [63:0]        mul_sh;
  logic [32:0]        mul_clip;
  logic signed [33:0] mul_res;
  logic               take, out_load;
  logic signed [31:0] bminx, bminy, bmaxx, bmaxy;

  assign take = q_valid_i && q_ready_o;

  // The x division starts as the item is taken, the y division as x ends.
  assign div_force = (state_q == pes_pkg::StIdle) ? q_data_i.force_x : w_q.force_y;
  assign div_mass  = (state_q == pes_pkg::StIdle) ? q_data_i.mass : w_q.mass;

  pes_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .force_i (div_force),
    .mass_i  (div_mass),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Shared step multiplier: (a * dt) >> FracBits, truncated toward zero.
  // A magnitude beyond 2^32 is clamped there, since it saturates the sum anyway.
  always_comb begin
    unique case (state_q)
      pes_pkg::StVelX: mul_a = ax_q;
      pes_pkg::StVelY: mul_a = ay_q;
      pes_pkg::StPosX: mul_a = vx_q;
      default:         mul_a = vy_q;
    endcase
    mul_mag = mul_a[31] ? (32'd0 - mul_a) : mul_a;
    mul_full = 64'(mul_mag) * 64'(w_q.time_step);
    mul_sh = mul_full >> pes_pkg::FracBits;
    mul_clip = (mul_sh[63:32] != 32'd0) ? 33'h1_0000_0000 : {1'b0, mul_sh[31:0]};
    mul_res = mul_a[31] ? -$signed({1'b0, mul_clip}) : $signed({1'b0, mul_clip});
  end

  // Control sequence for one particle.
  always_comb begin
    state_d = state_q;
    q_ready_o = 1'b0;
    div_start = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      pes_pkg::StIdle: begin
        q_ready_o = 1'b1;
        if (q_valid_i) state_d = q_data_i.alive ? pes_pkg::StDivX : pes_pkg::StOut;
      end
      pes_pkg::StDivX: if (div_done) state_d = pes_pkg::StDivY;
      pes_pkg::StDivY: if (div_done) state_d = pes_pkg::StVelX;
      pes_pkg::StVelX: state_d = pes_pkg::StVelY;
      pes_pkg::StVelY: state_d = pes_pkg::StVelSum;
      pes_pkg::StVelSum: state_d = pes_pkg::StPosX;
      pes_pkg::StPosX: state_d = pes_pkg::StPosY;
      pes_pkg::StPosY: state_d = pes_pkg::StPosSum;
      pes_pkg::StPosSum: state_d = pes_pkg::StOut;
      pes_pkg::StOut: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d = pes_pkg::StIdle;
        end
      end
      default: state_d = pes_pkg::StIdle;
    endcase
    if (take && q_data_i.alive) div_start = 1'b1;
    if (state_q == pes_pkg::StDivX && div_done) div_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pes_pkg::StIdle;
    else state_q <= state_d;
  end

  // Working registers; the y division reads its force and mass from the captured item.
  always_ff @(posedge clk_i) begin
    if (take) begin
      w_q <= q_data_i;
      vx_q <= q_data_i.vel_x;
      vy_q <= q_data_i.vel_y;
      px_q <= q_data_i.pos_x;
      py_q <= q_data_i.pos_y;
    end
    if (state_q == pes_pkg::StDivX && div_done) ax_q <= div_quot;
    if (state_q == pes_pkg::StDivY && div_done) ay_q <= div_quot;
    if (state_q == pes_pkg::StVelX || state_q == pes_pkg::StPosX) prod_q <= mul_res;
    if (state_q == pes_pkg::StVelY || state_q == pes_pkg::StPosY) prod_y_q <= mul_res;
    if (state_q == pes_pkg::StVelSum) begin
      vx_q <= pes_pkg::sat32(34'(vx_q) + prod_q);
      vy_q <= pes_pkg::sat32(34'(vy_q) + prod_y_q);
    end
    if (state_q == pes_pkg::StPosSum) begin
      px_q <= pes_pkg::sat32(34'(px_q) + prod_q);
      py_q <= pes_pkg::sat32(34'(py_q) + prod_y_q);
    end
  end

  // Box update applied as the result is loaded.
  always_comb begin
    bminx = w_q.first_of_frame ? pes_pkg::MaxVal : min_x_q;
    bminy = w_q.first_of_frame ? pes_pkg::MaxVal : min_y_q;
    bmaxx = w_q.first_of_frame ? pes_pkg::MinVal : max_x_q;
    bmaxy = w_q.first_of_frame ? pes_pkg::MinVal : max_y_q;
    if (w_q.alive) begin
      if (px_q < bminx) bminx = px_q;
      if (py_q < bminy) bminy = py_q;
      if (px_q > bmaxx) bmaxx = px_q;
      if (py_q > bmaxy) bmaxy = py_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= pes_pkg::MaxVal;
      min_y_q <= pes_pkg::MaxVal;
      max_x_q <= pes_pkg::MinVal;
      max_y_q <= pes_pkg::MinVal;
      out_valid_o <= 1'b0;
    end else begin
      if (out_load) begin
        min_x_q <= bminx;
        min_y_q <= bminy;
        max_x_q <= bmaxx;
        max_y_q <= bmaxy;
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_o.new_pos_x <= px_q;
      out_data_o.new_pos_y <= py_q;
      out_data_o.new_vel_x <= vx_q;
      out_data_o.new_vel_y <= vy_q;
      out_data_o.new_age <= w_q.new_age;
      out_data_o.alive <= w_q.alive;
      out_data_o.box_min_x <= bminx;
      out_data_o.box_min_y <= bminy;
      out_data_o.box_max_x <= bmaxx;
      out_data_o.box_max_y <= bmaxy;
    end
  end

endmodule
`default_nettype wire

/* src/particle_euler_step_with_extent_core.sv */
// Path: a dead particle goes from its input through the queue straight to the
// result register; a live one goes through the queue, the bit-serial divider
// run once per axis, the step states VelX, VelY, VelSum, PosX, PosY, PosSum and
// the result register load. The back end holds one particle at a time, and
// output stalls can hold it; a two-entry queue buffers input.
// Reset: rst_ni clears control state and sets the bounding box to empty.
`default_nettype none
module particle_euler_step_with_extent_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pes_in_if.sink    in_if,
  pes_out_if.source out_if
);

  logic           q_valid, q_ready;
  pes_pkg::work_t q_data;

  pes_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_data_i  (in_if.data),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  pes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );

`ifndef SYNTHESIS
  // A live result lies inside the box, so its x minimum never exceeds its x maximum.
  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.alive |->
      out_if.data.box_min_x <= out_if.data.box_max_x)
    else $error("box min exceeds max for a live result");
  // A live result has positive age.
  a_alive_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.alive |-> out_if.data.new_age > 32'sd0)
    else $error("live result with nonpositive age");
  // Queue handoff happens only when the back end is free.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready |=> !q_ready)
    else $error("back end took two items in a row");
`endif

endmodule
`default_nettype wire
